// File: rtl/sbs_pkg.sv
`timescale 1ns / 1ps

package sbs_pkg;

    localparam int IN_W      = 40;
    localparam int OUT_W     = 28;
    localparam int CNT_W     = 5;
    localparam int Q_W       = 32;
    localparam int RCP_SHIFT = 43;
    localparam int SPLIT     = 22;
    localparam int TAB_W     = 44;
    localparam int SCL_W     = 33 + 16;
    localparam int PP_W      = Q_W + SPLIT;
    localparam int SUM_W     = 76;

    localparam logic [OUT_W-1:0] ROOT_MAX = {OUT_W{1'b1}};
    localparam logic [Q_W:0]     Q_ONE    = {1'b1, {Q_W{1'b0}}};

    typedef struct packed {
        logic             zero;
        logic [CNT_W-1:0] cnt;
        logic [Q_W-1:0]   u;
    } item_t;

endpackage

// File: rtl/sbs_front.sv
`timescale 1ns / 1ps

module sbs_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        value_valid,
    output logic                        value_ready,
    input  logic [sbs_pkg::IN_W-1:0]    value,
    output logic                        push_valid,
    input  logic                        push_ready,
    output sbs_pkg::item_t              push_item
);

    localparam int MAX_CNT = (sbs_pkg::IN_W - FRAC_BITS + 1) / 2;

    logic                         hold_valid_reg;
    logic                         hold_valid_next;
    logic [sbs_pkg::IN_W-1:0]     value_reg;
    logic [sbs_pkg::CNT_W-1:0]    cnt;
    logic [6:0]                   shamt;
    logic [sbs_pkg::IN_W+31:0]    wide;
    logic [sbs_pkg::Q_W:0]        r;
    logic [sbs_pkg::Q_W:0]        u_full;

    assign value_ready = !hold_valid_reg || push_ready;
    assign push_valid  = hold_valid_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (value_valid && value_ready)
        begin
            hold_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (value_valid && value_ready)
        begin
            value_reg <= value;
        end
    end

    // The shift count is the least one that brings the operand to one or below.
    always_comb
    begin
        cnt = sbs_pkg::CNT_W'(MAX_CNT);
        for (int c = MAX_CNT; c >= 0; c--)
        begin
            if ({1'b0, value_reg} <= (41'd1 << (FRAC_BITS + 2 * c)))
            begin
                cnt = sbs_pkg::CNT_W'(c);
            end
        end
    end

    assign shamt  = 7'(FRAC_BITS) + {1'b0, cnt, 1'b0};
    assign wide   = {value_reg, 32'd0} >> shamt;
    assign r      = wide[sbs_pkg::Q_W:0];
    assign u_full = sbs_pkg::Q_ONE - r;

    always_comb
    begin
        push_item.zero = (value_reg == '0);
        push_item.cnt  = cnt;
        push_item.u    = u_full[sbs_pkg::Q_W-1:0];
    end

endmodule

// File: rtl/sbs_queue.sv
`timescale 1ns / 1ps

module sbs_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  sbs_pkg::item_t  push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output sbs_pkg::item_t  pop_item
);

    sbs_pkg::item_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_push;
    logic           do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/sbs_back.sv
`timescale 1ns / 1ps

module sbs_back #(
    parameter int TERMS     = 100,
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pop_valid,
    output logic                        pop_ready,
    input  sbs_pkg::item_t              pop_item,
    output logic                        root_valid,
    input  logic                        root_ready,
    output logic [sbs_pkg::OUT_W-1:0]   root
);

    localparam int JW = $clog2(TERMS + 2);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_PP   = 3'd2;
    localparam logic [2:0] S_QT   = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_SCL  = 3'd5;

    logic [2:0]                     state_reg;
    logic [2:0]                     state_next;
    logic [JW-1:0]                  j_reg;
    logic [JW-1:0]                  j_next;
    logic                           pend_reg;
    logic                           pend_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [sbs_pkg::OUT_W-1:0]      root_reg;
    logic [sbs_pkg::Q_W-1:0]        u_reg;
    logic [sbs_pkg::CNT_W-1:0]      cnt_reg;
    logic [sbs_pkg::Q_W-1:0]        m_reg;
    logic [sbs_pkg::Q_W:0]          s_reg;
    logic [sbs_pkg::Q_W-1:0]        p_reg;
    logic [sbs_pkg::TAB_W-1:0]      r3_reg;
    logic [sbs_pkg::TAB_W-1:0]      c_reg;
    logic [sbs_pkg::PP_W-1:0]       pl_reg;
    logic [sbs_pkg::PP_W-1:0]       ph_reg;

    logic [sbs_pkg::TAB_W-1:0]      r3_tab [2:TERMS+1];
    logic [sbs_pkg::TAB_W-1:0]      c_tab  [2:TERMS+1];

    logic [2*sbs_pkg::Q_W-1:0]      prod;
    logic [sbs_pkg::SUM_W-1:0]      qsum;
    logic [sbs_pkg::Q_W-1:0]        quot;
    logic [sbs_pkg::Q_W:0]          s_upd;
    logic [sbs_pkg::Q_W-1:0]        half_u;
    logic [sbs_pkg::SCL_W-1:0]      root_w;
    logic [sbs_pkg::OUT_W-1:0]      root_sat;
    logic                           out_free;

    // Division by 2j is a multiplication by a rounded-up reciprocal; the table
    // holds three times that reciprocal and the rounding offset (2j-1) times it.
    for (genvar g = 2; g <= TERMS + 1; g++)
    begin : g_rcp
        localparam logic [63:0] RCP = ((64'd1 << sbs_pkg::RCP_SHIFT) + 64'(2 * g) - 64'd1)
                                      / 64'(2 * g);
        localparam logic [sbs_pkg::TAB_W-1:0] R3 = sbs_pkg::TAB_W'(RCP * 64'd3);
        localparam logic [sbs_pkg::TAB_W-1:0] CC = sbs_pkg::TAB_W'(RCP * 64'(2 * g - 1));
        assign r3_tab[g] = R3;
        assign c_tab[g]  = CC;
    end

    assign pop_ready  = (state_reg == S_IDLE);
    assign root_valid = out_valid_reg;
    assign root       = root_reg;
    assign out_free   = !out_valid_reg || root_ready;

    assign prod   = m_reg * u_reg;
    assign qsum   = ({22'd0, ph_reg} << sbs_pkg::SPLIT) + {22'd0, pl_reg}
                    + {32'd0, c_reg};
    assign quot   = qsum[sbs_pkg::RCP_SHIFT +: sbs_pkg::Q_W];
    assign s_upd  = ({1'b0, m_reg} >= s_reg) ? '0 : s_reg - {1'b0, m_reg};
    assign half_u = {1'b0, pop_item.u[sbs_pkg::Q_W-1:1]};
    assign root_w = ({16'd0, s_reg} << cnt_reg) >> (32 - FRAC_BITS);
    assign root_sat = (root_w > sbs_pkg::SCL_W'(sbs_pkg::ROOT_MAX))
                      ? sbs_pkg::ROOT_MAX : root_w[sbs_pkg::OUT_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        j_next         = j_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !root_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    j_next    = JW'(2);
                    pend_next = 1'b0;
                    state_next = pop_item.zero ? S_SCL : S_MUL;
                end
            end
            S_MUL:
            begin
                pend_next  = 1'b0;
                state_next = S_PP;
            end
            S_PP:
            begin
                state_next = S_QT;
            end
            S_QT:
            begin
                pend_next = 1'b1;
                if (j_reg == JW'(TERMS + 1))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    j_next     = j_reg + 1'b1;
                    state_next = S_MUL;
                end
            end
            S_FIN:
            begin
                state_next = S_SCL;
            end
            S_SCL:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            j_reg         <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            j_reg         <= j_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (pop_valid)
                begin
                    u_reg   <= pop_item.u;
                    cnt_reg <= pop_item.cnt;
                    m_reg   <= half_u;
                    s_reg   <= pop_item.zero ? '0 : sbs_pkg::Q_ONE - {1'b0, half_u};
                end
            end
            S_MUL:
            begin
                p_reg  <= prod[2*sbs_pkg::Q_W-1:sbs_pkg::Q_W];
                r3_reg <= r3_tab[j_reg];
                c_reg  <= c_tab[j_reg];
                if (pend_reg)
                begin
                    s_reg <= s_upd;
                end
            end
            S_PP:
            begin
                pl_reg <= p_reg * r3_reg[sbs_pkg::SPLIT-1:0];
                ph_reg <= p_reg * r3_reg[sbs_pkg::TAB_W-1:sbs_pkg::SPLIT];
            end
            S_QT:
            begin
                m_reg <= p_reg - quot;
            end
            S_FIN:
            begin
                s_reg <= s_upd;
            end
            S_SCL:
            begin
                if (out_free)
                begin
                    root_reg <= root_sat;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: rtl/sqrt_binomial_series_unit.sv
`timescale 1ns / 1ps

// Channel   Handshake                  Payload
// input     value_valid / value_ready  value [39:0], UQ24.16
// output    root_valid / root_ready    root  [27:0], UQ12.16, saturating
//
// A nonzero transaction steps through the series engine term by term and a zero one goes straight to scaling:
// each term passes the multiply, the reciprocal multiply and the subtraction steps in turn.
// The range reduction runs ahead and a two-entry queue holds reduced operands.
// Reset is asynchronous and active low; there is no clearing pass.
// A stalled output holds the engine in its final step until root_ready rises.

module sqrt_binomial_series_unit #(
    parameter int TERMS     = 100,
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        value_valid,
    output logic                        value_ready,
    input  logic [sbs_pkg::IN_W-1:0]    value,
    output logic                        root_valid,
    input  logic                        root_ready,
    output logic [sbs_pkg::OUT_W-1:0]   root
);

    logic           push_valid;
    logic           push_ready;
    sbs_pkg::item_t push_item;
    logic           pop_valid;
    logic           pop_ready;
    sbs_pkg::item_t pop_item;

    sbs_front #(
        .FRAC_BITS(FRAC_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .value_valid(value_valid),
        .value_ready(value_ready),
        .value      (value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    sbs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    sbs_back #(
        .TERMS    (TERMS),
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .root_valid (root_valid),
        .root_ready (root_ready),
        .root       (root)
    );

endmodule
